@@ rtl/pnc_pkg.sv @@
// Package for the positive neighbor count unit: constants, payload types,
// the job record passed from the front end to the back end, and a bit counter.
// No dependencies.
`timescale 1ns / 1ps

package pnc_pkg;

  localparam int MaxRowsDef = 1024;
  localparam int MaxColsDef = 32;

  localparam int SampleW  = 16;
  localparam int CountW   = 4;
  localparam int RowIdxW  = 10;
  localparam int ColIdxW  = 5;
  localparam int RowsW    = 11;
  localparam int ColsW    = 6;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 11;
  localparam int NumRes   = 4;
  localparam int QDepth   = 4;
  localparam int QAddrW   = 2;
  localparam int QCntW    = 3;

  localparam logic [CfgIdxW-1:0] CfgNumRows = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 1'd1;

  localparam logic [RowsW-1:0] RowsReset = 11'd1024;
  localparam logic [ColsW-1:0] ColsReset = 6'd32;

  // Slots of one job, in the order the results leave the unit.
  localparam logic [1:0] ResAbove    = 2'd0;
  localparam logic [1:0] ResAboveEnd = 2'd1;
  localparam logic [1:0] ResLast     = 2'd2;
  localparam logic [1:0] ResLastEnd  = 2'd3;

  localparam logic [1:0] Slot0 = 2'd0;
  localparam logic [1:0] Slot1 = 2'd1;
  localparam logic [1:0] Slot2 = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0]  neighbor_count;
    logic [RowIdxW-1:0] row_index;
    logic [ColIdxW-1:0] col_index;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [NumRes-1:0]             mask;
    logic [NumRes-1:0][CountW-1:0] count;
    logic [RowIdxW-1:0]            row_lo;
    logic [ColIdxW-1:0]            col_lo;
  } job_t;

  function automatic logic [CountW-1:0] cnt8(input logic [7:0] v);
    logic [CountW-1:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + CountW'(v[k]);
    end
    return n;
  endfunction

endpackage

@@ rtl/pnc_stream_if.sv @@
// Valid/ready stream interface with a typed payload.
// No dependencies; the payload type is given where the interface is instantiated.
`timescale 1ns / 1ps

interface pnc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/pnc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pnc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pnc_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on pnc_pkg.
`timescale 1ns / 1ps

module pnc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pnc_pkg::job_t push_job,
  output logic          full,
  output logic          valid,
  output pnc_pkg::job_t head,
  input  logic          pop
);

  pnc_pkg::job_t                   mem_r [pnc_pkg::QDepth];
  logic [pnc_pkg::QAddrW-1:0]      wp_r, rp_r;
  logic [pnc_pkg::QCntW-1:0]       cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == pnc_pkg::QCntW'(pnc_pkg::QDepth));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("Queue occupancy did not grow on a lone push.");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("Queue occupancy did not shrink on a lone pop.");

endmodule

@@ rtl/pnc_front.sv @@
// Front end: configuration registers, raster position, three line stores of
// positive flags and the 3x3 window that turns samples into jobs of counts.
// Depends on pnc_pkg and pnc_ram.
`timescale 1ns / 1ps

module pnc_front #(
  parameter int MAX_ROWS = pnc_pkg::MaxRowsDef,
  parameter int MAX_COLS = pnc_pkg::MaxColsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pnc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [pnc_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  input  logic signed [pnc_pkg::SampleW-1:0]  in_sample,
  output logic                                in_ready,
  output logic                                push,
  output pnc_pkg::job_t                       push_job,
  input  logic                                q_full
);

  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef struct packed {
    logic                            pos;
    logic [1:0]                      slot;
    logic [pnc_pkg::RowIdxW-1:0]     row_lo;
    logic [pnc_pkg::ColIdxW-1:0]     col_lo;
    logic                            r_ge1;
    logic                            r_ge2;
    logic                            c_ge1;
    logic                            c_ge2;
    logic                            c_last;
    logic                            r_last;
  } stage_t;

  logic [pnc_pkg::RowsW-1:0] num_rows_r;
  logic [pnc_pkg::ColsW-1:0] num_cols_r;
  logic [31:0]               rows_eff, cols_eff;
  logic [RowW-1:0]           last_row;
  logic [ColW-1:0]           last_col;

  logic [RowW-1:0] row_r, row_nxt;
  logic [ColW-1:0] col_r, col_nxt;
  logic [1:0]      slot_r, slot_nxt;

  logic       acc, positive, s1_go;
  logic [2:0] ram_we, ram_q;
  logic       s1_valid_r;
  stage_t     s1_r;
  logic [2:0] w1_r, w2_r, k0, k1, k2;
  logic       top, mid;

  always_comb begin
    rows_eff = 32'(num_rows_r);
    if (num_rows_r == '0) begin
      rows_eff = 32'd1;
    end else if (rows_eff > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end
    cols_eff = 32'(num_cols_r);
    if (num_cols_r == '0) begin
      cols_eff = 32'd1;
    end else if (cols_eff > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end
    last_row = RowW'(rows_eff - 32'd1);
    last_col = ColW'(cols_eff - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= pnc_pkg::RowsReset;
      num_cols_r <= pnc_pkg::ColsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        pnc_pkg::CfgNumRows: num_rows_r <= cfg_data[pnc_pkg::RowsW-1:0];
        pnc_pkg::CfgNumCols: num_cols_r <= cfg_data[pnc_pkg::ColsW-1:0];
        default: ;
      endcase
    end
  end

  assign acc      = in_valid && in_ready;
  assign positive = (in_sample != '0) && !in_sample[pnc_pkg::SampleW-1];

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (cfg_we) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = pnc_pkg::Slot0;
    end else if (acc) begin
      if (col_r == last_col) begin
        col_nxt = '0;
        if (row_r == last_row) begin
          row_nxt  = '0;
          slot_nxt = pnc_pkg::Slot0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = (slot_r == pnc_pkg::Slot2) ? pnc_pkg::Slot0 : slot_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= pnc_pkg::Slot0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // One line store per row slot; the slot of the current row is written
  // while the other two are read at the same column.
  for (genvar i = 0; i < 3; i++) begin : g_line
    assign ram_we[i] = acc && (slot_r == 2'(i));

    pnc_ram #(
      .WIDTH(1),
      .DEPTH(MAX_COLS)
    ) u_line (
      .clk  (clk),
      .we   (ram_we[i]),
      .waddr(col_r),
      .wdata(positive),
      .re   (acc),
      .raddr(col_r),
      .rdata(ram_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.pos    <= positive;
      s1_r.slot   <= slot_r;
      s1_r.row_lo <= pnc_pkg::RowIdxW'(row_r);
      s1_r.col_lo <= pnc_pkg::ColIdxW'(col_r);
      s1_r.r_ge1  <= (row_r != '0);
      s1_r.r_ge2  <= (row_r > RowW'(1));
      s1_r.c_ge1  <= (col_r != '0);
      s1_r.c_ge2  <= (col_r > ColW'(1));
      s1_r.c_last <= (col_r == last_col);
      s1_r.r_last <= (row_r == last_row);
    end
  end

  always_comb begin
    case (s1_r.slot)
      pnc_pkg::Slot0: begin
        mid = ram_q[2];
        top = ram_q[1];
      end
      pnc_pkg::Slot1: begin
        mid = ram_q[0];
        top = ram_q[2];
      end
      default: begin
        mid = ram_q[1];
        top = ram_q[0];
      end
    endcase
  end

  // Window columns are {row above above, row above, current row}.
  assign k0 = {top & s1_r.r_ge2, mid & s1_r.r_ge1, s1_r.pos};
  assign k1 = w1_r & {3{s1_r.c_ge1}};
  assign k2 = w2_r & {3{s1_r.c_ge2}};

  always_comb begin
    push_job        = '0;
    push_job.row_lo = s1_r.row_lo;
    push_job.col_lo = s1_r.col_lo;
    push_job.mask[pnc_pkg::ResAbove]    = s1_r.r_ge1 && s1_r.c_ge1;
    push_job.mask[pnc_pkg::ResAboveEnd] = s1_r.r_ge1 && s1_r.c_last;
    push_job.mask[pnc_pkg::ResLast]     = s1_r.r_last && s1_r.c_ge1;
    push_job.mask[pnc_pkg::ResLastEnd]  = s1_r.r_last && s1_r.c_last;
    push_job.count[pnc_pkg::ResAbove] =
      pnc_pkg::cnt8({k0[2], k0[1], k0[0], k1[2], k1[0], k2[2], k2[1], k2[0]});
    push_job.count[pnc_pkg::ResAboveEnd] =
      pnc_pkg::cnt8({3'b000, k0[2], k0[0], k1[2], k1[1], k1[0]});
    push_job.count[pnc_pkg::ResLast] =
      pnc_pkg::cnt8({3'b000, k0[1], k0[0], k1[1], k2[1], k2[0]});
    push_job.count[pnc_pkg::ResLastEnd] =
      pnc_pkg::cnt8({5'b00000, k0[1], k1[1], k1[0]});
  end

  assign s1_go    = s1_valid_r && (!q_full || (push_job.mask == '0));
  assign push     = s1_valid_r && !q_full && (push_job.mask != '0);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      w2_r <= w1_r;
      w1_r <= k0;
    end
  end

  a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_valid_r)
    else $error("An accepted sample did not reach the window stage.");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (row_r == '0) && (col_r == '0) && (slot_r == pnc_pkg::Slot0))
    else $error("A register write did not restart the frame.");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_r) && $stable(ram_q)))
    else $error("A stalled window stage lost its contents.");

endmodule

@@ rtl/pnc_back.sv @@
// Back end: takes jobs from the queue and sends their results one per
// transfer through an output register. Depends on pnc_pkg.
`timescale 1ns / 1ps

module pnc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pnc_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pnc_pkg::out_item_t out_item
);

  pnc_pkg::job_t                 job_r;
  logic [pnc_pkg::NumRes-1:0]    mask_r, mask_nxt;
  logic                          out_valid_r;
  pnc_pkg::out_item_t            out_item_r;

  logic                          use_held, load;
  pnc_pkg::job_t                 src_job;
  logic [pnc_pkg::NumRes-1:0]    src_mask, pick, remain;
  logic [1:0]                    idx;

  assign use_held = (mask_r != '0);
  assign src_job  = use_held ? job_r : q_head;
  assign src_mask = use_held ? mask_r : (q_valid ? q_head.mask : '0);
  assign load     = (src_mask != '0) && (!out_valid_r || out_ready);
  assign q_pop    = load && !use_held;

  always_comb begin
    idx  = pnc_pkg::ResLastEnd;
    pick = '0;
    for (int k = pnc_pkg::NumRes - 1; k >= 0; k--) begin
      if (src_mask[k]) begin
        idx = 2'(k);
      end
    end
    pick[idx] = 1'b1;
    remain    = src_mask & ~pick;
  end

  assign mask_nxt = load ? remain : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (load) begin
      out_item_r.neighbor_count <= src_job.count[idx];
      out_item_r.row_index <=
        ((idx == pnc_pkg::ResAbove) || (idx == pnc_pkg::ResAboveEnd)) ?
        src_job.row_lo - 1'b1 : src_job.row_lo;
      out_item_r.col_index <=
        ((idx == pnc_pkg::ResAbove) || (idx == pnc_pkg::ResLast)) ?
        src_job.col_lo - 1'b1 : src_job.col_lo;
      out_item_r.last_of_run <= (remain == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (remain == '0)) |=> (mask_r == '0) && out_item_r.last_of_run)
    else $error("The final result of a job left work behind.");

endmodule

@@ rtl/positive_neighbor_count_3x3_unit.sv @@
// Top level of the positive neighbor count unit.
// Depends on pnc_pkg, pnc_stream_if, pnc_front, pnc_fifo and pnc_back.
//
//   Channel  Dir  Payload                                           Transfer
//   in_ch    in   sample_value                                      valid & ready
//   out_ch   out  neighbor_count, row_index, col_index, last_of_run valid & ready
//   cfg_*    in   cfg_index, cfg_data                               cfg_we
//
// One sample is taken per cycle while the job queue has room; its first result passes the window
// stage, the job queue and the output register, and further results follow one per cycle while out_ch is ready.
// Samples of the last row yield up to four results each, so the single output port
// holds back the input there once the four-entry job queue is full.
// Reset is synchronous and restarts the frame; a register write restarts it too.
// Either side may stall at any time without losing or repeating a transfer.
`timescale 1ns / 1ps

module positive_neighbor_count_3x3_unit #(
  parameter int MAX_ROWS = pnc_pkg::MaxRowsDef,
  parameter int MAX_COLS = pnc_pkg::MaxColsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pnc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pnc_pkg::CfgDataW-1:0] cfg_data,
  pnc_stream_if.sink                   in_ch,
  pnc_stream_if.source                 out_ch
);

  logic               push, q_full, q_valid, q_pop, out_valid;
  pnc_pkg::job_t      push_job, q_head;
  pnc_pkg::out_item_t out_item;
  logic               in_ready;

  pnc_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_ch.valid),
    .in_sample(in_ch.data.sample_value),
    .in_ready (in_ready),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  pnc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head),
    .pop     (q_pop)
  );

  pnc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_item (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule
